// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/hogch_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hogch_pkg
// Types and fixed constants of the HOG cell orientation histogram.
// ---------------------------------------------------------------------------
package hogch_pkg;

    // Field widths
    localparam int MAG_W  = 16;
    localparam int ANG_W  = 16;
    localparam int IDX_W  = 4;
    localparam int SUM_W  = 22;
    localparam int FOLD_W = 15;   // folded angle, at most 23040
    localparam int FRAC_W = 12;   // offset inside a bin, below 2560
    localparam int PROD_W = MAG_W + FRAC_W;
    localparam int Q_W    = PROD_W - 9;  // product divided by 512

    // Angle geometry, 1/128 degree units
    localparam logic [ANG_W-1:0] HALF_TURN = 16'd23040;
    localparam int               BIN_WIDTH = 2560;
    localparam int               NUM_BINS  = 9;

    // x / 5 == (x * 419431) >> 21 for all x below 699050
    localparam logic [18:0] RECIP_5     = 19'd419431;
    localparam int          RECIP_SHIFT = 21;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    typedef logic [IDX_W-1:0] bin_t;

    localparam bin_t BIN_COUNT = 4'd9;
    localparam bin_t BIN_LAST  = 4'd8;

    // Split of one pixel's magnitude between two neighbouring bins
    typedef struct packed {
        bin_t             lower;
        bin_t             upper;
        logic [MAG_W-1:0] share;  // goes to the upper bin
        logic [MAG_W-1:0] rest;   // goes to the lower bin
    } weight_t;

endpackage

// File: rtl/hogch_weight.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hogch_weight
// Three-stage pipeline that folds the angle, finds the two bins and splits
// the magnitude between them with exact floor division by 2560.
// ---------------------------------------------------------------------------
module hogch_weight
    import hogch_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [MAG_W-1:0] magnitude,
    input  logic [ANG_W-1:0] angle,
    output logic             out_valid,
    output weight_t          out_w
);

    typedef struct packed {
        bin_t              lower;
        bin_t              upper;
        logic [FRAC_W-1:0] frac;
        logic [MAG_W-1:0]  mag;
    } bins_t;

    typedef struct packed {
        bin_t              lower;
        bin_t              upper;
        logic [PROD_W-1:0] prod;
        logic [MAG_W-1:0]  mag;
    } prod_t;

    logic    s1_valid_reg, s2_valid_reg, s3_valid_reg;
    bins_t   s1_reg, s1_next;
    prod_t   s2_reg, s2_next;
    weight_t s3_reg, s3_next;

    // Stage 1: fold by 180 degrees at most twice, then locate the bin
    always_comb
    begin
        logic [ANG_W-1:0]  a1;
        logic [ANG_W-1:0]  a2;
        logic [FOLD_W-1:0] fold;
        logic [FOLD_W-1:0] base;
        bin_t              lower;
        a1    = (angle > HALF_TURN) ? angle - HALF_TURN : angle;
        a2    = (a1 > HALF_TURN) ? a1 - HALF_TURN : a1;
        fold  = a2[FOLD_W-1:0];
        lower = '0;
        base  = '0;
        for (int k = 1; k <= NUM_BINS; k++)
        begin
            if (fold >= FOLD_W'(k * BIN_WIDTH))
            begin
                lower = IDX_W'(k);
                base  = FOLD_W'(k * BIN_WIDTH);
            end
        end
        s1_next.frac = FRAC_W'(fold - base);
        // exactly 180 degrees lands on bin 0
        s1_next.lower = (lower == BIN_COUNT) ? '0 : lower;
        s1_next.upper = (s1_next.lower == BIN_LAST) ? '0 : s1_next.lower + 4'd1;
        s1_next.mag   = magnitude;
    end

    // Stage 2: magnitude times offset
    always_comb
    begin
        s2_next.lower = s1_reg.lower;
        s2_next.upper = s1_reg.upper;
        s2_next.mag   = s1_reg.mag;
        s2_next.prod  = PROD_W'(s1_reg.mag) * PROD_W'(s1_reg.frac);
    end

    // Stage 3: divide by 512 with a shift, then by 5 with a reciprocal
    always_comb
    begin
        logic [Q_W-1:0]    q;
        logic [Q_W+18:0]   scaled;
        logic [MAG_W-1:0]  share;
        q      = s2_reg.prod[PROD_W-1:9];
        scaled = (Q_W+19)'(q) * (Q_W+19)'(RECIP_5);
        share  = scaled[RECIP_SHIFT +: MAG_W];
        s3_next.lower = s2_reg.lower;
        s3_next.upper = s2_reg.upper;
        s3_next.share = share;
        s3_next.rest  = s2_reg.mag - share;
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_w     = s3_reg;

endmodule

// File: rtl/hog_cell_histogram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hog_cell_histogram
// Nine-bin orientation histogram over square cells of gradient pixels.
// ---------------------------------------------------------------------------
// Takes one gradient pixel (magnitude, angle) per cycle in cell order and,
// once a cell's last pixel is through the weight stages and cell buffer,
// gives its nine bin sums in order 0..8, tlast on bin 8. The input runs at
// one pixel per cycle; the fully pipelined weight path (fold, multiply,
// reciprocal multiply) and the single accumulate stage set that figure.
// A nine-entry buffer holds a finished cell while the next one is
// accumulated and feeds a registered output stage, so the input ready never
// depends on the output ready. The input stalls only when a cell completes
// while bins of the previous cell are still waiting in the buffer (the bin
// in the output register does not count), so with cells of at least ten
// pixels and a consumer that takes a bin every cycle it never stalls.
// ---------------------------------------------------------------------------
module hog_cell_histogram
    import hogch_pkg::*;
#(
    parameter int CELL_SIDE = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] magnitude, [31:16] angle
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [3:0] bin_index, [25:4] bin_value, rest 0
    output logic        m_axis_tlast    // last_bin
);

    localparam int CELL_PIXELS = CELL_SIDE * CELL_SIDE;
    localparam int CNT_W       = $clog2(CELL_PIXELS);
    localparam logic [CNT_W-1:0] LAST_PIX = CNT_W'(CELL_PIXELS - 1);

    logic             in_valid_reg;
    logic [MAG_W-1:0] mag_reg;
    logic [ANG_W-1:0] ang_reg;

    logic    w_valid;
    weight_t w;

    logic [CNT_W-1:0] pix_cnt_reg;
    logic [SUM_W-1:0] acc_reg  [NUM_BINS];
    logic [SUM_W-1:0] acc_next [NUM_BINS];

    logic [SUM_W-1:0] snap_reg [NUM_BINS];
    bin_t             snap_idx_reg;
    logic             snap_valid_reg;

    logic             out_valid_reg;
    bin_t             out_idx_reg;
    logic [SUM_W-1:0] out_value_reg;

    logic advance;
    logic cell_done;
    logic snap_free;
    logic snap_move;

    // Pipeline control: whole pipe holds while a finished cell cannot be parked
    assign snap_move = snap_valid_reg && (!out_valid_reg || m_axis_tready);
    assign snap_free = !snap_valid_reg;
    assign cell_done = w_valid && (pix_cnt_reg == LAST_PIX);
    assign advance   = !cell_done || snap_free;

    assign s_axis_tready = advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (advance)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mag_reg <= s_axis_tdata[15:0];
            ang_reg <= s_axis_tdata[31:16];
        end
    end

    hogch_weight u_weight (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (in_valid_reg),
        .magnitude (mag_reg),
        .angle     (ang_reg),
        .out_valid (w_valid),
        .out_w     (w)
    );

    // Saturating add of the split into each bin
    always_comb
    begin
        logic [MAG_W-1:0] add;
        logic [SUM_W:0]   sum;
        for (int b = 0; b < NUM_BINS; b++)
        begin
            if (w.upper == IDX_W'(b))
                add = w.share;
            else if (w.lower == IDX_W'(b))
                add = w.rest;
            else
                add = '0;
            sum = {1'b0, acc_reg[b]} + (SUM_W+1)'(add);
            acc_next[b] = sum[SUM_W] ? SUM_MAX : sum[SUM_W-1:0];
        end
    end

    // Accumulators and pixel counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_cnt_reg <= '0;
            for (int b = 0; b < NUM_BINS; b++)
                acc_reg[b] <= '0;
        end
        else if (advance && w_valid)
        begin
            if (cell_done)
            begin
                pix_cnt_reg <= '0;
                for (int b = 0; b < NUM_BINS; b++)
                    acc_reg[b] <= '0;
            end
            else
            begin
                pix_cnt_reg <= pix_cnt_reg + CNT_W'(1);
                for (int b = 0; b < NUM_BINS; b++)
                    acc_reg[b] <= acc_next[b];
            end
        end
    end

    // Cell buffer control: index and valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
            snap_idx_reg   <= '0;
        end
        else if (advance && cell_done)
        begin
            snap_valid_reg <= 1'b1;
            snap_idx_reg   <= '0;
        end
        else if (snap_move)
        begin
            snap_idx_reg <= snap_idx_reg + 4'd1;
            if (snap_idx_reg == BIN_LAST)
                snap_valid_reg <= 1'b0;
        end
    end

    // Cell buffer data: loaded with the cell, shifted down per bin moved out
    always_ff @(posedge clk)
    begin
        if (advance && cell_done)
        begin
            for (int b = 0; b < NUM_BINS; b++)
                snap_reg[b] <= acc_next[b];
        end
        else if (snap_move)
        begin
            for (int b = 0; b < NUM_BINS - 1; b++)
                snap_reg[b] <= snap_reg[b+1];
        end
    end

    // Output register: valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (snap_move)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // Output register: data
    always_ff @(posedge clk)
    begin
        if (snap_move)
        begin
            out_idx_reg   <= snap_idx_reg;
            out_value_reg <= snap_reg[0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_value_reg, out_idx_reg};
    assign m_axis_tlast  = (out_idx_reg == BIN_LAST);

endmodule

// File: rtl/hogch_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hogch_checker
// Port-level checks on the histogram output stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hogch_checker
    import hogch_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    logic [3:0]  out_idx;
    logic        out_take;
    logic        out_stall;
    logic [32:0] out_word;
    logic        seq_ok;
    logic [3:0]  next_idx_reg;

    assign out_idx   = m_axis_tdata[3:0];
    assign out_take  = m_axis_tvalid && m_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_word  = {m_axis_tlast, m_axis_tdata};
    assign seq_ok    = m_axis_tvalid && (out_idx == next_idx_reg);

    // Bin number that must follow the one just taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            next_idx_reg <= '0;
        else if (out_take)
            next_idx_reg <= out_idx + 4'd1;
    end

    // tlast marks bin 8 and nothing else
    `ASSERT_SAME(a_last_on_bin8, clk, rst_n, m_axis_tvalid && m_axis_tlast, out_idx == BIN_LAST, "tlast off bin 8")

    // bin number never leaves 0..8
    `ASSERT_SAME(a_bin_range, clk, rst_n, m_axis_tvalid, out_idx <= BIN_LAST, "bin index above 8")

    // bins of a cell leave back to back in ascending order
    `ASSERT_NEXT(a_bin_order, clk, rst_n, out_take && !m_axis_tlast, seq_ok, "bin sequence broken")

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid && $stable(out_word), "stalled result changed")

endmodule

bind hog_cell_histogram hogch_checker u_hogch_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nine-bin HOG cell orientation histogram.
// ---------------------------------------------------------------------------
// Pixels go in as stream requests, starting with a short table of corner
// cases: bin centres, 180 and 360 degrees, angles beyond 360, extreme
// magnitudes and midpoint splits. After that come random cells, some of them
// all full-scale magnitude on one centre to reach the largest bin sums. An
// in-bench histogram model predicts the nine bins of each finished cell, and
// every bin request that leaves the block is checked against the oldest
// prediction. Both sides idle and stall at random, except over the last cell.
// ---------------------------------------------------------------------------
module tb_top;
    import hogch_pkg::*;

    localparam int CELL_SIDE   = 8;
    localparam int CELL_PIXELS = CELL_SIDE * CELL_SIDE;
    localparam int DIR_ROWS    = 21;
    localparam int TOTAL_ITEMS = 7 * CELL_PIXELS;
    localparam int IDLE_LIMIT  = 1000;

    // One bin request as the block should present it
    typedef struct packed {
        bin_t             index;
        logic [SUM_W-1:0] value;
        logic             last;
    } bin_result_t;

    // One pixel of stimulus; typed rows carry their bin contributions
    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic [ANG_W-1:0] angle;
        logic             typed;
        bin_t             lo_bin;
        logic [MAG_W-1:0] lo_add;
        bin_t             hi_bin;
        logic [MAG_W-1:0] hi_add;
    } pixel_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    // Histogram model state
    logic [SUM_W-1:0] hist_sums [NUM_BINS];
    int unsigned      cell_fill = 0;
    bin_result_t      bin_expect_q [$];

    pixel_row_t directed_rows [DIR_ROWS];
    int         mismatches = 0;
    int         hold_left = 0;
    int         idle_cycles = 0;
    bit         tail_calm = 1'b0;

    always #5 clk = ~clk;

    hog_cell_histogram #(
        .CELL_SIDE (CELL_SIDE)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    function automatic pixel_row_t plain_row(input logic [MAG_W-1:0] mag,
                                             input logic [ANG_W-1:0] ang);
        pixel_row_t r;
        r           = '0;
        r.magnitude = mag;
        r.angle     = ang;
        return r;
    endfunction

    function automatic pixel_row_t typed_row(input logic [MAG_W-1:0] mag,
                                             input logic [ANG_W-1:0] ang,
                                             input bin_t lo, input logic [MAG_W-1:0] lo_amt,
                                             input bin_t hi, input logic [MAG_W-1:0] hi_amt);
        pixel_row_t r;
        r        = plain_row(mag, ang);
        r.typed  = 1'b1;
        r.lo_bin = lo;
        r.lo_add = lo_amt;
        r.hi_bin = hi;
        r.hi_add = hi_amt;
        return r;
    endfunction

    // Saturating add into one bin
    task automatic add_to_hist(input int unsigned bin, input int unsigned amount);
        int unsigned total;
        total = hist_sums[bin] + amount;
        if (total > SUM_MAX)
            total = SUM_MAX;
        hist_sums[bin] = total[SUM_W-1:0];
    endtask

    // Fold, split and accumulate one pixel, or add a typed row's given contributions; close the cell on its last pixel
    task automatic predict_pixel(input pixel_row_t r);
        int unsigned folded;
        int unsigned lower;
        int unsigned upper;
        int unsigned offset;
        int unsigned share;
        bin_result_t res;
        if (r.typed)
        begin
            add_to_hist(r.lo_bin, r.lo_add);
            add_to_hist(r.hi_bin, r.hi_add);
        end
        else
        begin
            folded = r.angle;
            if (folded > HALF_TURN)
                folded -= HALF_TURN;
            if (folded > HALF_TURN)
                folded -= HALF_TURN;
            lower  = folded / BIN_WIDTH;
            offset = folded % BIN_WIDTH;
            if (lower >= NUM_BINS)
                lower -= NUM_BINS;
            if (offset == 0)
                add_to_hist(lower, r.magnitude);
            else
            begin
                upper = (lower + 1 >= NUM_BINS) ? 0 : lower + 1;
                share = (r.magnitude * offset) / BIN_WIDTH;
                add_to_hist(upper, share);
                add_to_hist(lower, r.magnitude - share);
            end
        end
        cell_fill++;
        if (cell_fill == CELL_PIXELS)
        begin
            for (int k = 0; k < NUM_BINS; k++)
            begin
                res.index = bin_t'(k);
                res.value = hist_sums[k];
                res.last  = (res.index == BIN_LAST);
                bin_expect_q = {bin_expect_q, res};
                hist_sums[k] = '0;
            end
            cell_fill = 0;
        end
    endtask

    // Optional idle burst, then hold the request until it is taken
    task automatic send_pixel(input pixel_row_t r);
        if (!tail_calm && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r.angle, r.magnitude};
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        predict_pixel(r);
        @(posedge clk);
    endtask

    // Result side: stall at random in bursts
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (!tail_calm && $urandom_range(0, 11) == 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= $urandom_range(0, 18);
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Check each bin request against the oldest prediction
    always @(negedge clk)
    begin
        bin_result_t want;
        bin_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.index = m_axis_tdata[3:0];
            got.value = m_axis_tdata[25:4];
            got.last  = m_axis_tlast;
            if (bin_expect_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected bin request: expected none, actual bin %0d value %0d",
                         $time, got.index, got.value);
            end
            else
            begin
                want = bin_expect_q.pop_front();
                if (got.index !== want.index || got.value !== want.value ||
                    got.last !== want.last || m_axis_tdata[31:26] !== '0)
                begin
                    mismatches++;
                    $display("%0t: expected bin %0d value %0d last %0b pad 0, actual bin %0d value %0d last %0b pad %0h",
                             $time, want.index, want.value, want.last,
                             got.index, got.value, got.last, m_axis_tdata[31:26]);
                end
            end
        end
    end

    // Watchdog on cycles with no request taken on either side
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles == IDLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        int         cell_no;
        bit         max_cell;
        logic [15:0] max_angle;
        logic [15:0] mag;
        logic [15:0] ang;
        max_cell  = 1'b0;
        max_angle = '0;
        foreach (hist_sums[k])
            hist_sums[k] = '0;

        // Corner cases; typed rows give the bin contributions by hand
        directed_rows = '{
            typed_row(16'd0,     16'd0,     4'd0, 16'd0,     4'd0, 16'd0),
            typed_row(16'd65535, 16'd0,     4'd0, 16'd65535, 4'd0, 16'd0),
            typed_row(16'd65535, 16'd2560,  4'd1, 16'd65535, 4'd1, 16'd0),
            typed_row(16'd65535, 16'd20480, 4'd8, 16'd65535, 4'd8, 16'd0),
            typed_row(16'd1000,  16'd23040, 4'd0, 16'd1000,  4'd0, 16'd0),   // 180 deg
            typed_row(16'd1000,  16'd46080, 4'd0, 16'd1000,  4'd0, 16'd0),   // 360 deg
            typed_row(16'd100,   16'd1280,  4'd0, 16'd50,    4'd1, 16'd50),
            typed_row(16'd100,   16'd21760, 4'd8, 16'd50,    4'd0, 16'd50),  // wraps
            typed_row(16'd7,     16'd40960, 4'd7, 16'd7,     4'd7, 16'd0),   // 320 deg
            plain_row(16'd65535, 16'd1),
            plain_row(16'd65535, 16'd2559),
            plain_row(16'd65535, 16'd23041),
            plain_row(16'd65535, 16'd46079),
            plain_row(16'd65535, 16'd65535),    // folded twice
            plain_row(16'd65535, 16'd46081),
            plain_row(16'd1,     16'd1279),
            plain_row(16'd12345, 16'd22999),
            plain_row(16'hAAAA,  16'h5555),
            plain_row(16'h5555,  16'hAAAA),
            plain_row(16'd2560,  16'd10000),
            plain_row(16'd65535, 16'd23039)
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[d])
            send_pixel(directed_rows[d]);

        // Random cells
        for (int i = DIR_ROWS; i < TOTAL_ITEMS; i++)
        begin
            if (i % CELL_PIXELS == 0)
            begin
                cell_no = i / CELL_PIXELS;
                // hold off once until the finished cell has fully drained
                if (cell_no == 5)
                begin
                    s_axis_tvalid <= 1'b0;
                    do
                        @(posedge clk);
                    while (bin_expect_q.size() != 0);
                end
                max_cell  = (cell_no == 3) || ($urandom_range(0, 5) == 0);
                max_angle = 16'(2560 * $urandom_range(0, 18));
            end
            tail_calm = (i >= TOTAL_ITEMS - CELL_PIXELS);
            if (max_cell)
            begin
                mag = 16'hFFFF;
                ang = max_angle;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:       mag = 16'd0;
                    1:       mag = 16'hFFFF;
                    default: mag = 16'($urandom_range(0, 65535));
                endcase
                case ($urandom_range(0, 9))
                    0, 1:    ang = 16'(2560 * $urandom_range(0, 18));
                    2:       ang = 16'($urandom_range(46080, 65535));
                    3:       ang = 16'($urandom_range(0, 65535));
                    default: ang = 16'($urandom_range(0, 46079));
                endcase
            end
            send_pixel(plain_row(mag, ang));
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then allow for the output latency
        while (bin_expect_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/hogch_pkg.sv
rtl/hogch_weight.sv
rtl/hog_cell_histogram.sv
rtl/hogch_checker.sv
tb/tb_top.sv
